>>> hw/rtl/pidpi_pkg.sv
// Package: widths, register indexes and configuration type for the PID block.
`timescale 1ns / 1ps
`default_nettype none
package pidpi_pkg;

	// Q format of the gains
	localparam int GAIN_FRAC_BITS = 16;

	localparam int MEAS_W  = 16;
	localparam int ERR_W   = MEAS_W + 1;
	localparam int GAIN_W  = 32;
	localparam int TERM_W  = 32;
	localparam int PROD_W  = GAIN_W + TERM_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int DRIVE_W = 32;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;

	typedef enum logic [CIDX_W-1:0] {
		REG_SET_POINT     = 3'd0,
		REG_GAIN_P        = 3'd1,
		REG_GAIN_I        = 3'd2,
		REG_GAIN_D        = 3'd3,
		REG_INCREMENTAL   = 3'd4,
		REG_ADD_SET_POINT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [MEAS_W-1:0] set_point;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic                     incremental_mode;
		logic                     add_set_point;
	} cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/pidpi_terms.sv
// Error history and error sum, and the three gain terms for one item.
`timescale 1ns / 1ps
`default_nettype none
module pidpi_terms (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pidpi_pkg::cfg_t                      cfg,
	input  wire logic                                 step,
	input  wire logic signed [pidpi_pkg::MEAS_W-1:0]  meas,
	output logic signed [pidpi_pkg::TERM_W-1:0]       term_p,
	output logic signed [pidpi_pkg::TERM_W-1:0]       term_i,
	output logic signed [pidpi_pkg::TERM_W-1:0]       term_d
);
	import pidpi_pkg::*;

	// 32-bit signed limits, sign-extended by one bit
	localparam logic signed [TERM_W:0] SUM_MAX = {{2{1'b0}}, {(TERM_W-1){1'b1}}};
	localparam logic signed [TERM_W:0] SUM_MIN = {{2{1'b1}}, {(TERM_W-1){1'b0}}};

	logic signed [TERM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [ERR_W-1:0]  prior_error_q;

	logic signed [ERR_W-1:0]  err;
	logic signed [TERM_W:0]   sum_wide;
	logic signed [TERM_W-1:0] sum_next;
	logic signed [ERR_W:0]    diff1;
	logic signed [ERR_W+1:0]  diff2;

	// Form error, differences and saturated sum
	always_comb begin
		err      = ERR_W'(cfg.set_point) - ERR_W'(meas);
		sum_wide = (TERM_W+1)'(error_sum_q) + (TERM_W+1)'(err);
		if (sum_wide > SUM_MAX) begin
			sum_next = SUM_MAX[TERM_W-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_next = SUM_MIN[TERM_W-1:0];
		end else begin
			sum_next = sum_wide[TERM_W-1:0];
		end
		diff1 = (ERR_W+1)'(err) - (ERR_W+1)'(last_error_q);
		diff2 = (ERR_W+2)'(err) - ((ERR_W+2)'(last_error_q) <<< 1)
			+ (ERR_W+2)'(prior_error_q);
		if (cfg.incremental_mode) begin
			term_p = TERM_W'(diff1);
			term_i = TERM_W'(err);
			term_d = TERM_W'(diff2);
		end else begin
			term_p = TERM_W'(err);
			term_i = sum_next;
			term_d = TERM_W'(diff1);
		end
	end

	// Advance history; hold the sum in incremental mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q   <= '0;
			last_error_q  <= '0;
			prior_error_q <= '0;
		end else if (step) begin
			prior_error_q <= last_error_q;
			last_error_q  <= err;
			if (!cfg.incremental_mode) begin
				error_sum_q <= sum_next;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/pidpi_sat.sv
// Scale the accumulator down, truncating toward zero, and clamp to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module pidpi_sat (
	input  wire logic signed [pidpi_pkg::ACC_W-1:0]   acc,
	output logic signed [pidpi_pkg::DRIVE_W-1:0]      drive
);
	import pidpi_pkg::*;

	localparam int QW = ACC_W - GAIN_FRAC_BITS;
	// 32-bit signed limits, sign-extended to the quotient width
	localparam logic signed [QW-1:0] Q_MAX =
		{{(QW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN =
		{{(QW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

	logic signed [QW-1:0] q_floor;
	logic                 round_up;
	logic signed [QW-1:0] q_trunc;

	// Floor shift, then step negative values with a remainder back toward zero
	always_comb begin
		q_floor  = acc[ACC_W-1:GAIN_FRAC_BITS];
		round_up = acc[ACC_W-1] && (|acc[GAIN_FRAC_BITS-1:0]);
		q_trunc  = q_floor + QW'(round_up);
		if (q_trunc > Q_MAX) begin
			drive = Q_MAX[DRIVE_W-1:0];
		end else if (q_trunc < Q_MIN) begin
			drive = Q_MIN[DRIVE_W-1:0];
		end else begin
			drive = q_trunc[DRIVE_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/pid_positional_incremental.sv
// Top level: PID controller, positional or incremental form, one item per cycle while the output is not stalled.
// Pipeline: input accept to drive valid passes the input, terms, products, sum and output registers in order.
// Throughput: one item per cycle unless the output stalls; the error history loop closes in the terms stage.
// Each stage loads when empty or when the stage after it moves, so bubbles are absorbed.
// Reset: all configuration, error history, error sum and valid flags clear to zero.
`timescale 1ns / 1ps
`default_nettype none
module pid_positional_incremental (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [pidpi_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [pidpi_pkg::CDATA_W-1:0]        cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [pidpi_pkg::MEAS_W-1:0]  measurement,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [pidpi_pkg::DRIVE_W-1:0]      drive
);
	import pidpi_pkg::*;

	cfg_t cfg_q;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic signed [MEAS_W-1:0] meas_s1;
	logic signed [TERM_W-1:0] term_p_s2, term_i_s2, term_d_s2;
	logic signed [PROD_W-1:0] prod_p_s3, prod_i_s3, prod_d_s3;
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [DRIVE_W-1:0] drive_q;

	logic signed [TERM_W-1:0] term_p, term_i, term_d;
	logic signed [DRIVE_W-1:0] drive_sat;
	logic signed [ACC_W-1:0]  sp_scaled;
	logic ld_out, ld4, ld3, ld2, ld1;

	// Configuration writes, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_POINT:     cfg_q.set_point        <= cfg_data[MEAS_W-1:0];
				REG_GAIN_P:        cfg_q.gain_p           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:        cfg_q.gain_i           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:        cfg_q.gain_d           <= cfg_data[GAIN_W-1:0];
				REG_INCREMENTAL:   cfg_q.incremental_mode <= cfg_data[0];
				REG_ADD_SET_POINT: cfg_q.add_set_point    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Stage load enables, walking back from the output register
	always_comb begin
		ld_out = !out_valid_q || out_ready;
		ld4    = !valid_s4 || ld_out;
		ld3    = !valid_s3 || ld4;
		ld2    = !valid_s2 || ld3;
		ld1    = !valid_s1 || ld2;
	end

	assign in_ready = ld1;

	pidpi_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (valid_s1 && ld2),
		.meas   (meas_s1),
		.term_p (term_p),
		.term_i (term_i),
		.term_d (term_d)
	);

	assign sp_scaled = ACC_W'(cfg_q.set_point) <<< GAIN_FRAC_BITS;

	pidpi_sat u_sat (
		.acc   (acc_s4),
		.drive (drive_sat)
	);

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= in_valid;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3;
			if (ld_out) out_valid_q <= valid_s4;
		end
	end

	// Payload stages: input, terms, products, sum, output
	always_ff @(posedge clk) begin
		if (ld1) begin
			meas_s1 <= measurement;
		end
		if (ld2) begin
			term_p_s2 <= term_p;
			term_i_s2 <= term_i;
			term_d_s2 <= term_d;
		end
		if (ld3) begin
			prod_p_s3 <= cfg_q.gain_p * term_p_s2;
			prod_i_s3 <= cfg_q.gain_i * term_i_s2;
			prod_d_s3 <= cfg_q.gain_d * term_d_s2;
		end
		if (ld4) begin
			acc_s4 <= ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3)
				+ (cfg_q.add_set_point ? sp_scaled : '0);
		end
		if (ld_out) begin
			drive_q <= drive_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule
`default_nettype wire

>>> hw/rtl/pidpi_checker.sv
// Port-level checks for the PID block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pidpi_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [pidpi_pkg::DRIVE_W-1:0] drive
);
	import pidpi_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive))
		else $error("drive changed while stalled");

	// Backpressure reaches the input only through a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output free");

	// No result right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

endmodule

bind pid_positional_incremental pidpi_checker u_pidpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive)
);
`default_nettype wire

>>> tb/tb.sv
// Testbench for the PID controller: directed rows, an error sum ramp and random phases.
`timescale 1ns / 1ps
module tb;
	import pidpi_pkg::*;

	// indexes that no register answers to
	localparam logic [CIDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CIDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [GAIN_W-1:0] GAIN_ONE     = 32'h0001_0000;
	localparam logic [GAIN_W-1:0] GAIN_MAX     = 32'h7FFF_FFFF;
	localparam logic [GAIN_W-1:0] GAIN_MIN     = 32'h8000_0000;
	localparam logic [GAIN_W-1:0] WINDUP_GAIN_I = 32'h0000_0100;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint Q_ONE   = 64'sd1 <<< GAIN_FRAC_BITS;

	localparam int WATCHDOG_LIMIT    = 200;
	localparam int RANDOM_PHASES     = 8;
	localparam int ITEMS_PER_PHASE   = 89;
	localparam int WINDUP_UP_ITEMS   = 40;
	localparam int WINDUP_DOWN_ITEMS = 80;

	typedef struct {
		bit                        is_write;
		logic [CIDX_W-1:0]         idx;
		logic [CDATA_W-1:0]        data;
		logic signed [MEAS_W-1:0]  meas;
		bit                        has_fixed;
		logic signed [DRIVE_W-1:0] fixed_drive;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CIDX_W-1:0]         cfg_index = '0;
	logic [CDATA_W-1:0]        cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [MEAS_W-1:0]  measurement = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] drive;

	// typed expectation that travels with the item on the input side
	logic                      row_fixed = 1'b0;
	logic signed [DRIVE_W-1:0] row_fixed_drive = '0;
	logic                      idle_on = 1'b1;

	int stall_left = 0;
	int quiet_cycles = 0;
	int bad_count = 0;
	int results_seen = 0;

	logic signed [DRIVE_W-1:0] expected_drive[$];

	// controller state as seen by the checker
	cfg_t                    ctl = '0;
	logic signed [31:0]      sum_state = '0;
	logic signed [ERR_W-1:0] err_last = '0;
	logic signed [ERR_W-1:0] err_prior = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pid_positional_incremental dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive)
	);

	function automatic longint clamp_s32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// Advance the error history and sum by one item and return the drive it causes.
	function automatic logic signed [DRIVE_W-1:0] next_drive(logic signed [MEAS_W-1:0] m);
		longint sp, e, tp, ti, td, acc;
		sp = longint'($signed(ctl.set_point));
		e = sp - longint'(m);
		if (ctl.incremental_mode) begin
			tp = e - err_last;
			ti = e;
			td = e - 2 * err_last + err_prior;
		end else begin
			sum_state = 32'(clamp_s32(longint'(sum_state) + e));
			tp = e;
			ti = sum_state;
			td = e - err_last;
		end
		err_prior = err_last;
		err_last = ERR_W'(e);
		acc = longint'($signed(ctl.gain_p)) * tp + longint'($signed(ctl.gain_i)) * ti
			+ longint'($signed(ctl.gain_d)) * td;
		if (ctl.add_set_point)
			acc += sp * Q_ONE;
		return 32'(clamp_s32(acc / Q_ONE));
	endfunction

	function automatic void apply_write(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] d);
		case (idx)
			REG_SET_POINT:     ctl.set_point = d[MEAS_W-1:0];
			REG_GAIN_P:        ctl.gain_p = d;
			REG_GAIN_I:        ctl.gain_i = d;
			REG_GAIN_D:        ctl.gain_d = d;
			REG_INCREMENTAL:   ctl.incremental_mode = d[0];
			REG_ADD_SET_POINT: ctl.add_set_point = d[0];
			default: ;
		endcase
	endfunction

	function automatic plan_row_t write_row(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] d);
		plan_row_t r;
		r = '{1'b1, idx, d, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic plan_row_t item_row(logic signed [MEAS_W-1:0] m, bit fixed,
			logic signed [DRIVE_W-1:0] val);
		plan_row_t r;
		r = '{1'b0, '0, '0, m, fixed, val};
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] small_gain();
		logic [GAIN_W-1:0] g;
		g = $urandom_range(0, 32'h3_FFFF);
		return $urandom_range(0, 1) ? -g : g;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			3: return GAIN_ONE;
			4: return -GAIN_ONE;
			5: return $urandom();
			default: return small_gain();
		endcase
	endfunction

	// Hold the write until the block takes it; valid is lowered by the caller.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// Offer one item, after an optional gap, and hold it until accepted.
	task automatic send(input logic signed [MEAS_W-1:0] m, input bit fixed,
			input logic signed [DRIVE_W-1:0] fixed_val);
		int gap;
		gap = (idle_on && $urandom_range(0, 15) == 0) ? $urandom_range(1, 8) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measurement <= m;
		row_fixed <= fixed;
		row_fixed_drive <= fixed_val;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Stop sending and wait for every drive value still owed.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_drive.size() != 0);
		@(posedge clk);
	endtask

	// Stall the result side in random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Track writes, predict on each accepted item, check each accepted drive.
	always @(posedge clk) begin
		logic signed [DRIVE_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				want = next_drive(measurement);
				expected_drive.push_back(row_fixed ? row_fixed_drive : want);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_drive.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("drive %0d arrived with no item waiting", drive);
				end else begin
					want = expected_drive.pop_front();
					if (drive !== want) begin
						bad_count++;
						if (bad_count <= 10)
							$display("result %0d: expected drive %0d, got %0d",
								results_seen, want, drive);
					end
				end
			end
		end
	end

	// Count cycles in which no handshake completes.
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
				|| (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no handshake for %0d cycles, %0d drive values owed",
			quiet_cycles, expected_drive.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		bit writing;
		int ph, n;
		logic [CDATA_W-1:0] d;
		logic signed [MEAS_W-1:0] sp, m;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero gains after reset give zero drive
		plan.push_back(item_row(16'sh7FFF, 1'b1, 32'sd0));
		plan.push_back(item_row(16'sh8000, 1'b1, 32'sd0));
		// unity proportional gain at the widest error, set point added
		plan.push_back(write_row(REG_SET_POINT, 32'h0000_7FFF));
		plan.push_back(write_row(REG_GAIN_P, GAIN_ONE));
		plan.push_back(write_row(REG_ADD_SET_POINT, 32'h0000_0001));
		plan.push_back(item_row(16'sh8000, 1'b1, 32'sd98302));
		// largest gains drive the output into both limits
		plan.push_back(write_row(REG_GAIN_P, GAIN_MAX));
		plan.push_back(write_row(REG_GAIN_I, GAIN_MAX));
		plan.push_back(item_row(16'sh8000, 1'b1, 32'sh7FFF_FFFF));
		plan.push_back(write_row(REG_GAIN_P, GAIN_MIN));
		plan.push_back(write_row(REG_GAIN_I, GAIN_MIN));
		plan.push_back(item_row(16'sh8000, 1'b1, 32'sh8000_0000));
		// writes to unknown indexes leave everything as it was
		plan.push_back(write_row(REG_SPARE_6, 32'h0000_0000));
		plan.push_back(write_row(REG_SPARE_7, 32'hFFFF_FFFF));
		plan.push_back(item_row(16'sh8000, 1'b1, 32'sh8000_0000));
		// incremental form with a pure second difference, history carried over
		plan.push_back(write_row(REG_GAIN_P, 32'h0));
		plan.push_back(write_row(REG_GAIN_I, 32'h0));
		plan.push_back(write_row(REG_GAIN_D, GAIN_ONE));
		plan.push_back(write_row(REG_SET_POINT, 32'h0));
		plan.push_back(write_row(REG_ADD_SET_POINT, 32'hFFFF_FFFE));
		plan.push_back(write_row(REG_INCREMENTAL, 32'hA5A5_0001));
		plan.push_back(item_row(16'sh0000, 1'b0, '0));
		plan.push_back(item_row(16'sh1234, 1'b0, '0));
		plan.push_back(item_row(16'shEDCB, 1'b0, '0));
		// fractional gains, truncation toward zero on both signs
		plan.push_back(write_row(REG_GAIN_D, 32'hFFFF_8000));
		plan.push_back(write_row(REG_GAIN_P, 32'h0000_8000));
		plan.push_back(item_row(16'sh0001, 1'b0, '0));
		plan.push_back(item_row(16'shFFFF, 1'b0, '0));
		plan.push_back(item_row(16'sh7FFF, 1'b0, '0));
		plan.push_back(item_row(16'sh8000, 1'b0, '0));
		// back to positional with the lowest set point added
		plan.push_back(write_row(REG_INCREMENTAL, 32'hFFFF_FFFE));
		plan.push_back(write_row(REG_GAIN_I, 32'h0000_0001));
		plan.push_back(write_row(REG_ADD_SET_POINT, 32'h8000_0001));
		plan.push_back(write_row(REG_SET_POINT, 32'hFFFF_8000));
		plan.push_back(item_row(16'sh5555, 1'b0, '0));
		plan.push_back(item_row(16'shAAAA, 1'b0, '0));
		plan.push_back(item_row(16'sh0000, 1'b0, '0));

		writing = 1'b0;
		foreach (plan[k]) begin
			if (plan[k].is_write) begin
				if (!writing)
					drain();
				write_reg(plan[k].idx, plan[k].data);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_valid <= 1'b0;
				writing = 1'b0;
				send(plan[k].meas, plan[k].has_fixed, plan[k].fixed_drive);
			end
		end

		// ramp the error sum up at the widest error, then back down through zero
		drain();
		write_reg(REG_SET_POINT, 32'h0000_7FFF);
		write_reg(REG_GAIN_P, small_gain());
		write_reg(REG_GAIN_I, WINDUP_GAIN_I);
		write_reg(REG_GAIN_D, small_gain());
		write_reg(REG_ADD_SET_POINT, 32'h0);
		cfg_valid <= 1'b0;
		repeat (WINDUP_UP_ITEMS) send(16'sh8000, 1'b0, '0);
		drain();
		write_reg(REG_SET_POINT, 32'hFFFF_8000);
		cfg_valid <= 1'b0;
		repeat (WINDUP_DOWN_ITEMS) send(16'sh7FFF, 1'b0, '0);

		// random settings and measurements; the last phase runs without idling
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			idle_on <= (ph == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: sp = 16'sh7FFF;
				1: sp = 16'sh8000;
				default: sp = 16'($urandom());
			endcase
			d = $urandom();
			d[MEAS_W-1:0] = sp;
			write_reg(REG_SET_POINT, d);
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			write_reg(REG_INCREMENTAL, $urandom());
			write_reg(REG_ADD_SET_POINT, $urandom());
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
			cfg_valid <= 1'b0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ($urandom_range(0, 7))
					0: m = 16'sh7FFF;
					1: m = 16'sh8000;
					2: m = sp + $signed(16'($urandom_range(0, 64))) - 16'sd32;
					default: m = 16'($urandom());
				endcase
				send(m, 1'b0, '0);
			end
		end

		// drain, then keep watching for stray results
		drain();
		repeat (10) @(posedge clk);
		if (bad_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/pidpi_pkg.sv
hw/rtl/pidpi_terms.sv
hw/rtl/pidpi_sat.sv
hw/rtl/pid_positional_incremental.sv
hw/rtl/pidpi_checker.sv
tb/tb.sv
